>>> src/slfe_pkg.sv
// shared types, constants and functions of the serial line frame encoder
// no dependencies; used by every module of the block
package slfe_pkg;

  localparam int unsigned NUM_SLOTS = 8;

  // register indexes on the configuration port
  localparam logic [0:0] REG_FRAMING_MODE = 1'b0;
  localparam logic [0:0] REG_TX_ACCM      = 1'b1;

  // framing modes
  localparam logic MODE_SLIP = 1'b0;
  localparam logic MODE_PPP  = 1'b1;

  localparam logic [7:0] SLIP_END_BYTE = 8'hC0;
  localparam logic [7:0] SLIP_ESC_BYTE = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END  = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC  = 8'hDD;
  localparam logic [7:0] PPP_FLAG_BYTE = 8'h7E;
  localparam logic [7:0] PPP_ESC_BYTE  = 8'h7D;
  localparam logic [7:0] PPP_XOR       = 8'h20;

  localparam logic [15:0] FCS_INIT = 16'hFFFF;
  localparam logic [15:0] FCS_POLY = 16'h8408;
  localparam logic [31:0] ACCM_RESET = 32'hFFFF_FFFF;

  // slot order of one word's line bytes:
  // open flag, data prefix, data, fcs low prefix, fcs low, fcs high prefix, fcs high, close flag
  localparam int unsigned SLOT_OPEN    = 0;
  localparam int unsigned SLOT_D_PRE   = 1;
  localparam int unsigned SLOT_DATA    = 2;
  localparam int unsigned SLOT_LO_PRE  = 3;
  localparam int unsigned SLOT_LO      = 4;
  localparam int unsigned SLOT_HI_PRE  = 5;
  localparam int unsigned SLOT_HI      = 6;
  localparam int unsigned SLOT_CLOSE   = 7;

  // one classified word: which slots go out, and their bytes
  typedef struct packed {
    logic [NUM_SLOTS-1:0]      mask;
    logic [NUM_SLOTS-1:0][7:0] bytes;
  } slfe_job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } slfe_qstat_t;

  // crc-16/x.25 over one byte, reflected
  function automatic logic [15:0] fcs_byte(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] c;
    c = fcs ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ FCS_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // ppp escape decision for one byte under a given accm
  function automatic logic ppp_needs_esc(input logic [7:0] b, input logic [31:0] accm);
    logic esc;
    if (b[7:5] == 3'b000) begin
      esc = accm[b[4:0]];
    end else begin
      esc = (b == PPP_FLAG_BYTE) || (b == PPP_ESC_BYTE);
    end
    return esc;
  endfunction

endpackage

>>> src/serial_line_frame_encoder.sv
// top level of the serial line frame encoder (slip / ppp async hdlc transmit framer)
// depends on slfe_pkg, slfe_front, slfe_queue, slfe_back
//
// Transmit framer for a serial line. Each input word carries one payload byte with
// frame start / end marks and an escape-all-controls flag; the block answers with one
// to eight line bytes, the final one flagged by last_of_run. A front end accepts a word,
// updates the running fcs-16 and turns the word into a job that lists the line bytes to
// send; a queue of QUEUE_DEPTH jobs decouples it from a back end that sends exactly one
// line byte per clock into an output register while out_stall is low and jobs wait.
// Input words are taken back to back as long as the queue has room, so the sustained
// rate is set by the output side: a word yields one line byte for a plain byte, two for
// an escaped one, and up to eight for an escaped word that both opens and closes a ppp
// frame with escaped fcs bytes. An accepted word passes through the queue and the back
// end's current job register to the output register. framing_mode and tx_accm are
// written through the plain write port and must only change while the block is idle.
module serial_line_frame_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  input  logic        frame_end,
  input  logic        escape_all_controls,
  // output words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  line_byte,
  output logic        last_of_run
);

  logic                  framing_mode;
  logic [31:0]           tx_accm;
  logic                  push;
  logic                  pop;
  slfe_pkg::slfe_job_t   push_job;
  slfe_pkg::slfe_job_t   head_job;
  slfe_pkg::slfe_qstat_t qstat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      framing_mode <= slfe_pkg::MODE_SLIP;
      tx_accm      <= slfe_pkg::ACCM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        slfe_pkg::REG_FRAMING_MODE: framing_mode <= cfg_data[0];
        slfe_pkg::REG_TX_ACCM:      tx_accm      <= cfg_data;
        default: ;
      endcase
    end
  end

  // input is held off only while the job queue is full
  assign in_stall = qstat.full;

  // classify each word and keep the fcs
  slfe_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .data_byte           (data_byte),
    .frame_start         (frame_start),
    .frame_end           (frame_end),
    .escape_all_controls (escape_all_controls),
    .framing_mode        (framing_mode),
    .tx_accm             (tx_accm),
    .qstat               (qstat),
    .push                (push),
    .job                 (push_job)
  );

  // jobs waiting for the line
  slfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .qstat    (qstat)
  );

  // one line byte per cycle while the output is not stalled
  slfe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_job    (head_job),
    .qstat       (qstat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .line_byte   (line_byte),
    .last_of_run (last_of_run)
  );

endmodule

>>> src/slfe_front.sv
// front end: takes input words, runs the fcs and classifies each word into a job
// depends on slfe_pkg
module slfe_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [7:0]           data_byte,
  input  logic                 frame_start,
  input  logic                 frame_end,
  input  logic                 escape_all_controls,
  input  logic                 framing_mode,
  input  logic [31:0]          tx_accm,
  input  slfe_pkg::slfe_qstat_t qstat,
  output logic                 push,
  output slfe_pkg::slfe_job_t  job
);

  logic [15:0] running_fcs;
  logic [15:0] running_fcs_next;
  logic [15:0] fcs_base;
  logic [15:0] fcs_new;
  logic [15:0] fcs_out;
  logic [31:0] accm;
  logic        d_esc;
  logic        lo_esc;
  logic        hi_esc;
  logic        is_ppp;

  assign push   = in_valid && !qstat.full;
  assign is_ppp = (framing_mode == slfe_pkg::MODE_PPP);

  always_comb begin
    fcs_base = frame_start ? slfe_pkg::FCS_INIT : running_fcs;
    fcs_new  = slfe_pkg::fcs_byte(fcs_base, data_byte);
    fcs_out  = fcs_new ^ slfe_pkg::FCS_INIT;
    accm     = escape_all_controls ? slfe_pkg::ACCM_RESET : tx_accm;
    running_fcs_next = is_ppp ? fcs_new : fcs_base;

    if (is_ppp) begin
      d_esc = slfe_pkg::ppp_needs_esc(data_byte, accm);
    end else begin
      d_esc = (data_byte == slfe_pkg::SLIP_END_BYTE) || (data_byte == slfe_pkg::SLIP_ESC_BYTE);
    end
    lo_esc = slfe_pkg::ppp_needs_esc(fcs_out[7:0], accm);
    hi_esc = slfe_pkg::ppp_needs_esc(fcs_out[15:8], accm);

    job.mask = '0;
    job.mask[slfe_pkg::SLOT_OPEN]   = frame_start;
    job.mask[slfe_pkg::SLOT_D_PRE]  = d_esc;
    job.mask[slfe_pkg::SLOT_DATA]   = 1'b1;
    job.mask[slfe_pkg::SLOT_LO_PRE] = is_ppp && frame_end && lo_esc;
    job.mask[slfe_pkg::SLOT_LO]     = is_ppp && frame_end;
    job.mask[slfe_pkg::SLOT_HI_PRE] = is_ppp && frame_end && hi_esc;
    job.mask[slfe_pkg::SLOT_HI]     = is_ppp && frame_end;
    job.mask[slfe_pkg::SLOT_CLOSE]  = frame_end;

    job.bytes = '0;
    if (is_ppp) begin
      job.bytes[slfe_pkg::SLOT_OPEN]   = slfe_pkg::PPP_FLAG_BYTE;
      job.bytes[slfe_pkg::SLOT_D_PRE]  = slfe_pkg::PPP_ESC_BYTE;
      job.bytes[slfe_pkg::SLOT_DATA]   = d_esc ? (data_byte ^ slfe_pkg::PPP_XOR) : data_byte;
      job.bytes[slfe_pkg::SLOT_CLOSE]  = slfe_pkg::PPP_FLAG_BYTE;
    end else begin
      job.bytes[slfe_pkg::SLOT_OPEN]   = slfe_pkg::SLIP_END_BYTE;
      job.bytes[slfe_pkg::SLOT_D_PRE]  = slfe_pkg::SLIP_ESC_BYTE;
      if (!d_esc) begin
        job.bytes[slfe_pkg::SLOT_DATA] = data_byte;
      end else if (data_byte == slfe_pkg::SLIP_END_BYTE) begin
        job.bytes[slfe_pkg::SLOT_DATA] = slfe_pkg::SLIP_ESC_END;
      end else begin
        job.bytes[slfe_pkg::SLOT_DATA] = slfe_pkg::SLIP_ESC_ESC;
      end
      job.bytes[slfe_pkg::SLOT_CLOSE]  = slfe_pkg::SLIP_END_BYTE;
    end
    job.bytes[slfe_pkg::SLOT_LO_PRE] = slfe_pkg::PPP_ESC_BYTE;
    job.bytes[slfe_pkg::SLOT_LO]     = lo_esc ? (fcs_out[7:0] ^ slfe_pkg::PPP_XOR) : fcs_out[7:0];
    job.bytes[slfe_pkg::SLOT_HI_PRE] = slfe_pkg::PPP_ESC_BYTE;
    job.bytes[slfe_pkg::SLOT_HI]     = hi_esc ? (fcs_out[15:8] ^ slfe_pkg::PPP_XOR)
                                              : fcs_out[15:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_fcs <= slfe_pkg::FCS_INIT;
    end else if (push) begin
      running_fcs <= running_fcs_next;
    end
  end

endmodule

>>> src/slfe_queue.sv
// short job queue between front and back end
// depends on slfe_pkg
module slfe_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  slfe_pkg::slfe_job_t   push_job,
  input  logic                  pop,
  output slfe_pkg::slfe_job_t   head_job,
  output slfe_pkg::slfe_qstat_t qstat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  slfe_pkg::slfe_job_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == FULL_CNT);
  assign head_job    = slots[rd_ptr];
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

>>> src/slfe_back.sv
// back end: walks the slots of one job and drives one line byte per cycle while the output is not stalled
// depends on slfe_pkg
module slfe_back (
  input  logic                  clk,
  input  logic                  rst,
  input  slfe_pkg::slfe_job_t   head_job,
  input  slfe_pkg::slfe_qstat_t qstat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            line_byte,
  output logic                  last_of_run
);

  logic                                cur_valid;
  logic [slfe_pkg::NUM_SLOTS-1:0]      cur_mask;
  logic [slfe_pkg::NUM_SLOTS-1:0][7:0] cur_bytes;
  logic [2:0]                          sel;
  logic [slfe_pkg::NUM_SLOTS-1:0]      rem;
  logic                                found;
  logic                                out_free;
  logic                                advance;
  logic                                done;

  // lowest pending slot goes next
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < slfe_pkg::NUM_SLOTS; i++) begin
      if (cur_mask[i] && !found) begin
        sel   = 3'(i);
        found = 1'b1;
      end
    end
    rem      = cur_mask;
    rem[sel] = 1'b0;
    out_free = !out_valid || !out_stall;
    advance  = cur_valid && out_free;
    done     = advance && (rem == '0);
    pop      = !qstat.empty && (!cur_valid || done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      line_byte   <= cur_bytes[sel];
      last_of_run <= (rem == '0);
    end
    if (pop) begin
      cur_mask  <= head_job.mask;
      cur_bytes <= head_job.bytes;
    end else if (advance) begin
      cur_mask  <= rem;
    end
  end

endmodule

>>> src/slfe_checker.sv
// port-level checks of the serial line frame encoder, bound to the top level
// depends on slfe_pkg and serial_line_frame_encoder
module slfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wr_en,
  input logic [0:0]  cfg_index,
  input logic [31:0] cfg_data,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  line_byte,
  input logic        last_of_run
);

  logic       mode;
  logic       pending_prefix;
  logic [7:0] prefix;
  logic       out_take;

  assign prefix   = (mode == slfe_pkg::MODE_PPP) ? slfe_pkg::PPP_ESC_BYTE
                                                 : slfe_pkg::SLIP_ESC_BYTE;
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= slfe_pkg::MODE_SLIP;
      pending_prefix <= 1'b0;
    end else begin
      if (cfg_wr_en && (cfg_index == slfe_pkg::REG_FRAMING_MODE)) begin
        mode <= cfg_data[0];
      end
      if (out_take) begin
        pending_prefix <= (line_byte == prefix) && !last_of_run;
      end
    end
  end

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(line_byte) && $stable(last_of_run))
    else $error("output word changed while stalled");

  // after reset the output is empty and input is open
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // an escape prefix never ends a word's run
  a_prefix_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> line_byte != prefix)
    else $error("escape prefix sent as last byte of a run");

  // the byte after a prefix is never another prefix
  a_no_double_prefix: assert property (@(posedge clk) disable iff (rst)
    out_take && pending_prefix |-> line_byte != prefix)
    else $error("escape prefix followed by another prefix");

endmodule

bind serial_line_frame_encoder slfe_checker u_slfe_checker (.*);

>>> tb/slfe_line_checker.sv
`timescale 1ns / 100ps
// checker for the serial line frame encoder: watches the config port and both word channels,
// predicts the line bytes of every accepted input word and compares them in order
// depends on slfe_pkg for register indexes, framing modes and line byte codes
module slfe_line_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  input  logic        frame_end,
  input  logic        escape_all_controls,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  line_byte,
  input  logic        last_of_run,
  output int          fail_count,
  output int          pending_words
);

  typedef struct packed {
    logic [7:0] lbyte;
    logic       is_last;
  } line_word_t;

  line_word_t  expected_line_q[$];
  logic [7:0]  run_bytes[$];
  logic        cur_mode;
  logic [31:0] cur_accm;
  logic [15:0] line_fcs;

  function automatic logic [15:0] crc16_x25_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ slfe_pkg::FCS_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic add_ppp_byte(input logic [7:0] b, input logic [31:0] accm);
    logic hit;
    if (b < 8'd32) begin
      hit = accm[b[4:0]];
    end else begin
      hit = (b == slfe_pkg::PPP_FLAG_BYTE) || (b == slfe_pkg::PPP_ESC_BYTE);
    end
    if (hit) begin
      run_bytes.push_back(slfe_pkg::PPP_ESC_BYTE);
      run_bytes.push_back(b ^ slfe_pkg::PPP_XOR);
    end else begin
      run_bytes.push_back(b);
    end
  endtask

  task automatic add_slip_byte(input logic [7:0] b);
    if (b == slfe_pkg::SLIP_END_BYTE) begin
      run_bytes.push_back(slfe_pkg::SLIP_ESC_BYTE);
      run_bytes.push_back(slfe_pkg::SLIP_ESC_END);
    end else if (b == slfe_pkg::SLIP_ESC_BYTE) begin
      run_bytes.push_back(slfe_pkg::SLIP_ESC_BYTE);
      run_bytes.push_back(slfe_pkg::SLIP_ESC_ESC);
    end else begin
      run_bytes.push_back(b);
    end
  endtask

  task automatic predict_line_run(input logic [7:0] b, input logic s, input logic e,
                                  input logic a);
    logic [31:0] accm;
    logic [15:0] fcs_out;
    line_word_t  w;
    accm = a ? '1 : cur_accm;
    run_bytes.delete();
    if (s) line_fcs = slfe_pkg::FCS_INIT;
    if (cur_mode == slfe_pkg::MODE_SLIP) begin
      if (s) run_bytes.push_back(slfe_pkg::SLIP_END_BYTE);
      add_slip_byte(b);
      if (e) run_bytes.push_back(slfe_pkg::SLIP_END_BYTE);
    end else begin
      if (s) run_bytes.push_back(slfe_pkg::PPP_FLAG_BYTE);
      line_fcs = crc16_x25_step(line_fcs, b);
      add_ppp_byte(b, accm);
      if (e) begin
        fcs_out = ~line_fcs;
        add_ppp_byte(fcs_out[7:0], accm);
        add_ppp_byte(fcs_out[15:8], accm);
        run_bytes.push_back(slfe_pkg::PPP_FLAG_BYTE);
      end
    end
    foreach (run_bytes[i]) begin
      w.lbyte   = run_bytes[i];
      w.is_last = (i == run_bytes.size() - 1);
      expected_line_q.push_back(w);
    end
  endtask

  task automatic check_line_word();
    line_word_t w;
    if (expected_line_q.size() == 0) begin
      $error("line word %h (last_of_run %b) with nothing expected", line_byte, last_of_run);
      fail_count++;
    end else begin
      w = expected_line_q.pop_front();
      if (line_byte !== w.lbyte) begin
        $error("line_byte: expected %h, actual %h", w.lbyte, line_byte);
        fail_count++;
      end
      if (last_of_run !== w.is_last) begin
        $error("last_of_run: expected %b, actual %b", w.is_last, last_of_run);
        fail_count++;
      end
    end
  endtask

  initial begin
    fail_count    = 0;
    pending_words = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      cur_mode = slfe_pkg::MODE_SLIP;
      cur_accm = slfe_pkg::ACCM_RESET;
      line_fcs = slfe_pkg::FCS_INIT;
      expected_line_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          slfe_pkg::REG_FRAMING_MODE: cur_mode = cfg_data[0];
          slfe_pkg::REG_TX_ACCM:      cur_accm = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_line_word();
      if (in_valid && !in_stall) begin
        predict_line_run(data_byte, frame_start, frame_end, escape_all_controls);
      end
    end
    pending_words = expected_line_q.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// top of the serial line frame encoder testbench: clock, reset, stimulus and verdict
// depends on slfe_pkg, serial_line_frame_encoder and slfe_line_checker
module tb;

  localparam int SEG_WORDS     = 68;        // random words per config segment
  localparam int NUM_SEGS      = 6;
  localparam int DRAIN_SLACK   = 4;         // margin after the expectation store empties
  localparam int END_CYCLES    = 20;
  localparam int HOLD_AT_WORD  = 320;       // lands in a segment without idling
  localparam int HOLD_CYCLES   = 80;
  localparam int TIMEOUT_NS    = 5_000_000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        frame_start;
  logic        frame_end;
  logic        escape_all_controls;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  line_byte;
  logic        last_of_run;

  int fail_count;
  int pending_words;
  int words_sent     = 0;
  int send_idle_pct  = 7;
  int recv_idle_pct  = 54;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  serial_line_frame_encoder u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .data_byte           (data_byte),
    .frame_start         (frame_start),
    .frame_end           (frame_end),
    .escape_all_controls (escape_all_controls),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .line_byte           (line_byte),
    .last_of_run         (last_of_run)
  );

  slfe_line_checker u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .data_byte           (data_byte),
    .frame_start         (frame_start),
    .frame_end           (frame_end),
    .escape_all_controls (escape_all_controls),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .line_byte           (line_byte),
    .last_of_run         (last_of_run),
    .fail_count          (fail_count),
    .pending_words       (pending_words)
  );

  // receiver: random stall each cycle, plus one long hold-off once enough words went in
  // so the job queue fills and the block has to stall its input
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && words_sent >= HOLD_AT_WORD) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  // one word on the input channel; called at a falling edge and returns at one,
  // with valid still high so back-to-back words never drop it
  task automatic send_word(input logic [7:0] b, input logic s, input logic e, input logic a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid            = 1'b1;
    data_byte           = b;
    frame_start         = s;
    frame_end           = e;
    escape_all_controls = a;
    // payload holds until the rising edge that takes it
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  // every word yields at least one line byte, so an empty expectation store means idle
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // only bit 0 matters for the mode, the rest is noise
  task automatic set_mode(input logic m);
    logic [31:0] val;
    val    = $urandom;
    val[0] = m;
    write_reg(slfe_pkg::REG_FRAMING_MODE, val);
  endtask

  // payload bytes leaning toward the ones that get escaped
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0:       b = slfe_pkg::SLIP_END_BYTE;
          1:       b = slfe_pkg::SLIP_ESC_BYTE;
          2:       b = slfe_pkg::PPP_FLAG_BYTE;
          3:       b = slfe_pkg::PPP_ESC_BYTE;
          4:       b = 8'h00;
          default: b = 8'hFF;
        endcase
      end
      1, 2: begin
        b = 8'($urandom_range(31));
      end
      default: begin
        b = 8'($urandom);
      end
    endcase
    return b;
  endfunction

  // mostly well-formed frames of 1 to 8 words; some frames get random marks instead
  task automatic send_random_frame();
    int   len;
    bit   noisy;
    logic all_ctl;
    len     = $urandom_range(8, 1);
    noisy   = ($urandom_range(99) < 12);
    all_ctl = ($urandom_range(3) == 0);
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        send_word(pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else begin
        send_word(pick_byte(), i == 0, i == len - 1, all_ctl);
      end
    end
  endtask

  initial begin
    int seg_start;
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_index           = slfe_pkg::REG_FRAMING_MODE;
    cfg_data            = '0;
    in_valid            = 1'b0;
    data_byte           = '0;
    frame_start         = 1'b0;
    frame_end           = 1'b0;
    escape_all_controls = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // slip at reset config: both escapes, field extremes, start and end on one word
    send_word(slfe_pkg::SLIP_END_BYTE, 1'b1, 1'b0, 1'b0);
    send_word(slfe_pkg::SLIP_ESC_BYTE, 1'b0, 1'b0, 1'b1);
    send_word(8'h00, 1'b0, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b1, 1'b0);
    send_word(slfe_pkg::SLIP_END_BYTE, 1'b1, 1'b1, 1'b1);

    // ppp with every control byte escaped
    wait_drained();
    set_mode(slfe_pkg::MODE_PPP);
    write_reg(slfe_pkg::REG_TX_ACCM, 32'hFFFF_FFFF);
    send_word(slfe_pkg::PPP_FLAG_BYTE, 1'b1, 1'b0, 1'b0);
    send_word(slfe_pkg::PPP_ESC_BYTE, 1'b0, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0, 1'b0);
    send_word(8'h1F, 1'b0, 1'b0, 1'b0);
    send_word(8'h20, 1'b0, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b1, 1'b0);
    send_word(8'h11, 1'b1, 1'b1, 1'b1);
    // a word with no opening mark keeps the fcs running from where it was
    send_word(8'h41, 1'b0, 1'b1, 1'b0);

    // empty accm: controls pass unless escape-all is set, which covers the fcs bytes too
    wait_drained();
    write_reg(slfe_pkg::REG_TX_ACCM, 32'h0000_0000);
    send_word(8'h03, 1'b1, 1'b0, 1'b0);
    send_word(8'h03, 1'b0, 1'b0, 1'b1);
    send_word(slfe_pkg::PPP_FLAG_BYTE, 1'b0, 1'b1, 1'b1);

    // mode switch inside a frame: slip words leave the fcs alone, but a slip
    // start still resets it before the ppp frame is closed
    send_word(8'h10, 1'b1, 1'b0, 1'b0);
    wait_drained();
    set_mode(slfe_pkg::MODE_SLIP);
    send_word(8'h55, 1'b0, 1'b0, 1'b0);
    send_word(slfe_pkg::SLIP_END_BYTE, 1'b1, 1'b0, 1'b0);
    wait_drained();
    set_mode(slfe_pkg::MODE_PPP);
    send_word(8'h05, 1'b0, 1'b1, 1'b0);

    // random frames, two segments per idling phase, a new config each segment
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      wait_drained();
      case (seg / 2)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (seg)
        0: begin
          set_mode(slfe_pkg::MODE_PPP);
          write_reg(slfe_pkg::REG_TX_ACCM, $urandom);
        end
        1: begin
          set_mode(slfe_pkg::MODE_SLIP);
          write_reg(slfe_pkg::REG_TX_ACCM, $urandom);
        end
        2: begin
          set_mode(slfe_pkg::MODE_PPP);
          write_reg(slfe_pkg::REG_TX_ACCM, 32'h0000_0000);
        end
        3: begin
          write_reg(slfe_pkg::REG_TX_ACCM, 32'hFFFF_FFFF);
        end
        4: begin
          write_reg(slfe_pkg::REG_TX_ACCM, $urandom & $urandom);
        end
        default: begin
          write_reg(slfe_pkg::REG_TX_ACCM, $urandom | $urandom);
        end
      endcase
      seg_start = words_sent;
      while (words_sent - seg_start < SEG_WORDS) send_random_frame();
    end

    wait_drained();
    repeat (END_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/slfe_pkg.sv
src/slfe_front.sv
src/slfe_queue.sv
src/slfe_back.sv
src/serial_line_frame_encoder.sv
src/slfe_checker.sv
tb/slfe_line_checker.sv
tb/tb.sv
